### hw/rtl/lpmd_pkg.sv
package lpmd_pkg;

  // Default header field buffer depth
  localparam int unsigned HEADER_BUFFER_DEF = 64;

  localparam int unsigned CAP_W = 17;
  localparam int unsigned LEN_W = 17;

  localparam logic [CAP_W-1:0] CAP_RESET = 17'd4096;
  localparam logic [LEN_W-1:0] LEN_MAX   = 17'd99999;
  localparam logic [LEN_W-1:0] LEN_SAT   = 17'd100000;

  // Special bytes
  localparam logic [7:0] BYTE_BAR   = 8'h7C;
  localparam logic [7:0] BYTE_ONE   = 8'h31;
  localparam logic [7:0] BYTE_PLUS  = 8'h2B;
  localparam logic [7:0] BYTE_MINUS = 8'h2D;
  localparam logic [7:0] BYTE_SPACE = 8'h20;
  localparam logic [7:0] BYTE_ZERO  = 8'h30;

  // Parser phase codes
  localparam logic [2:0] PH_VERSION = 3'd0;
  localparam logic [2:0] PH_TYPE    = 3'd1;
  localparam logic [2:0] PH_LENGTH  = 3'd2;
  localparam logic [2:0] PH_BODY    = 3'd3;
  localparam logic [2:0] PH_DRAIN   = 3'd4;

  // Length field number form
  localparam logic [1:0] NF_SPACE  = 2'd0;
  localparam logic [1:0] NF_SIGN   = 2'd1;
  localparam logic [1:0] NF_DIGITS = 2'd2;
  localparam logic [1:0] NF_BAD    = 2'd3;

  // Result event codes
  localparam logic [3:0] EV_HEADER    = 4'd0;
  localparam logic [3:0] EV_BODY      = 4'd1;
  localparam logic [3:0] EV_DRAIN     = 4'd2;
  localparam logic [3:0] EV_ACCEPT    = 4'd3;
  localparam logic [3:0] EV_VERSION   = 4'd4;
  localparam logic [3:0] EV_TYPE      = 4'd5;
  localparam logic [3:0] EV_LENGTH    = 4'd6;
  localparam logic [3:0] EV_TOO_LARGE = 4'd7;
  localparam logic [3:0] EV_NO_BAR    = 4'd8;

  // One result word
  typedef struct packed {
    logic [3:0]       event_res;
    logic [7:0]       data_byte;
    logic [23:0]      type_code;
    logic [LEN_W-1:0] body_length;
  } lpmd_res_t;

endpackage

### hw/rtl/length_prefixed_message_deframer.sv
// Latency: a word accepted at one edge shows its result word from the next cycle.
// Throughput: one word per cycle while results are taken; the result register is
// refilled in the cycle it is taken, so input ready follows only the output side.
// Reset: rst_ni asynchronous, active low; parser returns to the version field,
// capacity_q returns to 4096, the result register empties.
module length_prefixed_message_deframer #(
  parameter int unsigned HEADER_BUFFER = lpmd_pkg::HEADER_BUFFER_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [lpmd_pkg::CAP_W-1:0]   cfg_wdata_i,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [7:0]                   byte_value_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [3:0]                   event_res_o,
  output logic [7:0]                   data_byte_o,
  output logic [23:0]                  type_code_o,
  output logic [lpmd_pkg::LEN_W-1:0]   body_length_o
);
  import lpmd_pkg::*;

  logic [CAP_W-1:0] capacity_q;
  logic             out_valid_q;
  lpmd_res_t        res_q;
  lpmd_res_t        res_d;
  logic             step;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign step       = in_valid_i && in_ready_o;

  lpmd_parser #(
    .HEADER_BUFFER(HEADER_BUFFER)
  ) u_parser (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_i    (step),
    .byte_i    (byte_value_i),
    .capacity_i(capacity_q),
    .res_o     (res_d)
  );

  // Capacity register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      capacity_q <= CAP_RESET;
    end else if (cfg_we_i) begin
      capacity_q <= cfg_wdata_i;
    end
  end

  // Result register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (step) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Result payload
  always_ff @(posedge clk_i) begin
    if (step) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign event_res_o   = res_q.event_res;
  assign data_byte_o   = res_q.data_byte;
  assign type_code_o   = res_q.type_code;
  assign body_length_o = res_q.body_length;

endmodule

### hw/rtl/lpmd_parser.sv
module lpmd_parser #(
  parameter int unsigned HEADER_BUFFER = lpmd_pkg::HEADER_BUFFER_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         step_i,
  input  logic [7:0]                   byte_i,
  input  logic [lpmd_pkg::CAP_W-1:0]   capacity_i,
  output lpmd_pkg::lpmd_res_t          res_o
);
  import lpmd_pkg::*;

  localparam int unsigned FC_W = $clog2(HEADER_BUFFER);
  localparam logic [FC_W-1:0] FC_LIMIT = FC_W'(HEADER_BUFFER - 1);

  logic [2:0]       phase_q, phase_d;
  logic [FC_W-1:0]  field_count_q, field_count_d;
  logic             version_good_q, version_good_d;
  logic [23:0]      type_bytes_q, type_bytes_d;
  logic [LEN_W-1:0] acc_q, acc_d;
  logic [1:0]       form_q, form_d;
  logic             neg_q, neg_d;
  logic [LEN_W-1:0] remaining_q, remaining_d;
  logic [LEN_W-1:0] decl_len_q, decl_len_d;

  logic [LEN_W-1:0] rem_dec;
  logic [FC_W-1:0]  fc_inc;
  logic [19:0]      acc_next;
  logic [LEN_W-1:0] len_val;
  logic             len_ok;
  logic             last;
  logic             done;
  logic [3:0]       ev;
  logic [7:0]       data;

  assign rem_dec  = remaining_q - 1'b1;
  assign fc_inc   = field_count_q + 1'b1;
  // acc * 10 + digit, wide enough for the saturated value
  assign acc_next = ({3'b000, acc_q} << 3) + ({3'b000, acc_q} << 1)
                  + {16'd0, byte_i[3:0]};

  // Length field verdict at its closing bar
  always_comb begin
    len_ok  = 1'b1;
    len_val = '0;
    if (field_count_q != '0) begin
      if (form_q != NF_DIGITS) begin
        len_ok = 1'b0;
      end else if (neg_q && (acc_q != '0)) begin
        len_ok = 1'b0;
      end else if (acc_q > LEN_MAX) begin
        len_ok = 1'b0;
      end else begin
        len_val = acc_q;
      end
    end
  end

  // Next state and result for one word
  always_comb begin
    phase_d        = phase_q;
    field_count_d  = field_count_q;
    version_good_d = version_good_q;
    type_bytes_d   = type_bytes_q;
    acc_d          = acc_q;
    form_d         = form_q;
    neg_d          = neg_q;
    remaining_d    = remaining_q;
    decl_len_d     = decl_len_q;
    ev             = EV_HEADER;
    data           = '0;
    done           = 1'b0;
    last           = (rem_dec == '0);

    if (phase_q inside {PH_BODY, PH_DRAIN}) begin
      remaining_d = rem_dec;
      if (phase_q == PH_DRAIN) begin
        ev = last ? EV_TOO_LARGE : EV_DRAIN;
      end else if (!last) begin
        ev   = EV_BODY;
        data = byte_i;
      end else if (byte_i == BYTE_BAR) begin
        ev   = EV_ACCEPT;
        data = byte_i;
      end else begin
        ev = EV_NO_BAR;
      end
      done = last;
    end else if (byte_i == BYTE_BAR) begin
      // End of a header field
      field_count_d = '0;
      case (phase_q)
        PH_VERSION: begin
          if ((field_count_q == FC_W'(1)) && version_good_q) begin
            phase_d = PH_TYPE;
          end else begin
            ev   = EV_VERSION;
            done = 1'b1;
          end
        end
        PH_TYPE: begin
          if (field_count_q == FC_W'(3)) begin
            phase_d = PH_LENGTH;
          end else begin
            ev   = EV_TYPE;
            done = 1'b1;
          end
        end
        default: begin
          if (!len_ok) begin
            ev   = EV_LENGTH;
            done = 1'b1;
          end else begin
            decl_len_d = len_val;
            if (({1'b0, len_val} + 18'd1) > {1'b0, capacity_i}) begin
              if (len_val == '0) begin
                ev   = EV_TOO_LARGE;
                done = 1'b1;
              end else begin
                phase_d     = PH_DRAIN;
                remaining_d = len_val;
              end
            end else if (len_val == '0) begin
              ev   = EV_NO_BAR;
              done = 1'b1;
            end else begin
              phase_d     = PH_BODY;
              remaining_d = len_val;
            end
          end
        end
      endcase
    end else begin
      // Header byte inside a field
      case (phase_q)
        PH_VERSION: begin
          version_good_d = (field_count_q == '0) && (byte_i == BYTE_ONE);
        end
        PH_TYPE: begin
          type_bytes_d = {type_bytes_q[15:0], byte_i};
        end
        default: begin
          if (byte_i inside {[8'h30:8'h39]}) begin
            if (form_q != NF_BAD) begin
              form_d = NF_DIGITS;
              acc_d  = (acc_next > {3'b000, LEN_SAT}) ? LEN_SAT : acc_next[LEN_W-1:0];
            end
          end else if ((byte_i == BYTE_PLUS) || (byte_i == BYTE_MINUS)) begin
            if (form_q == NF_SPACE) begin
              form_d = NF_SIGN;
              neg_d  = (byte_i == BYTE_MINUS);
            end else begin
              form_d = NF_BAD;
            end
          end else if (((byte_i == BYTE_SPACE) || (byte_i inside {[8'h09:8'h0D]}))
                       && (form_q == NF_SPACE)) begin
            form_d = form_q;
          end else begin
            form_d = NF_BAD;
          end
        end
      endcase
      field_count_d = fc_inc;
      // Field ran out of header buffer
      if (fc_inc >= FC_LIMIT) begin
        ev   = (phase_q == PH_VERSION) ? EV_VERSION :
               (phase_q == PH_TYPE)    ? EV_TYPE : EV_LENGTH;
        done = 1'b1;
      end
    end

    // Result carries values before any restart
    res_o.event_res   = ev;
    res_o.data_byte   = data;
    res_o.type_code   = type_bytes_d;
    res_o.body_length = decl_len_d;

    // Restart at the version field after an error or a finished message
    if (done) begin
      phase_d        = PH_VERSION;
      field_count_d  = '0;
      version_good_d = 1'b0;
      type_bytes_d   = '0;
      acc_d          = '0;
      form_d         = NF_SPACE;
      neg_d          = 1'b0;
      remaining_d    = '0;
      decl_len_d     = '0;
    end
  end

  // Parser state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q        <= PH_VERSION;
      field_count_q  <= '0;
      version_good_q <= 1'b0;
      type_bytes_q   <= '0;
      acc_q          <= '0;
      form_q         <= NF_SPACE;
      neg_q          <= 1'b0;
      remaining_q    <= '0;
      decl_len_q     <= '0;
    end else if (step_i) begin
      phase_q        <= phase_d;
      field_count_q  <= field_count_d;
      version_good_q <= version_good_d;
      type_bytes_q   <= type_bytes_d;
      acc_q          <= acc_d;
      form_q         <= form_d;
      neg_q          <= neg_d;
      remaining_q    <= remaining_d;
      decl_len_q     <= decl_len_d;
    end
  end

endmodule
